// ----- rtl/core/i2cseq_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cseq_pkg: shared types and codes for the i2c dma transaction sequencer
// event codes, reply codes, bus command codes and the result record
// ----------------------------------------------------------------------------
package i2cseq_pkg;

	localparam int COUNTER_WIDTH_DEFAULT = 16;
	localparam logic [7:0] STALL_LIMIT_RESET = 8'd3;
	localparam logic [7:0] TICK_MAX = 8'hFF;

	// event codes
	localparam logic [2:0] ACT_READ_REQ   = 3'd0;
	localparam logic [2:0] ACT_WRITE_REQ  = 3'd1;
	localparam logic [2:0] ACT_WR_RD_REQ  = 3'd2;
	localparam logic [2:0] ACT_DMA_DONE   = 3'd3;
	localparam logic [2:0] ACT_IRQ        = 3'd4;
	localparam logic [2:0] ACT_DELIVER    = 3'd5;
	localparam logic [2:0] ACT_WATCHDOG   = 3'd6;
	localparam logic [2:0] ACT_CLEAR_ERR  = 3'd7;

	// dma channels
	localparam logic CHAN_READ  = 1'b0;
	localparam logic CHAN_WRITE = 1'b1;

	// reply kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_WR_RD = 2'd3;

	// reply status
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_READ_ERR  = 2'd1;
	localparam logic [1:0] STS_WRITE_ERR = 2'd2;
	localparam logic [1:0] STS_OTHER_ERR = 2'd3;

	// dma masks
	localparam logic [1:0] DMA_NONE  = 2'b00;
	localparam logic [1:0] DMA_READ  = 2'b01;
	localparam logic [1:0] DMA_WRITE = 2'b10;
	localparam logic [1:0] DMA_BOTH  = 2'b11;

	// bus start commands
	localparam logic [1:0] BUS_NONE       = 2'd0;
	localparam logic [1:0] BUS_READ       = 2'd1;
	localparam logic [1:0] BUS_WRITE_STOP = 2'd2;
	localparam logic [1:0] BUS_WRITE_HOLD = 2'd3;

	// master-on-bus interrupt control
	localparam logic [1:0] MB_KEEP    = 2'd0;
	localparam logic [1:0] MB_ENABLE  = 2'd1;
	localparam logic [1:0] MB_DISABLE = 2'd2;

	// warnings
	localparam logic [1:0] WARN_NONE    = 2'd0;
	localparam logic [1:0] WARN_IRQ     = 2'd1;
	localparam logic [1:0] WARN_DMA     = 2'd2;
	localparam logic [1:0] WARN_STALL   = 2'd3;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [1:0]  reply_status;
		logic [1:0]  abort_mask;
		logic [1:0]  queue_mask;
		logic [1:0]  bus_start;
		logic [6:0]  bus_address;
		logic [7:0]  bus_length;
		logic [1:0]  mb_irq_control;
		logic        recover_bus;
		logic [1:0]  warning;
		logic [15:0] bus_error_total;
		logic [15:0] stall_recoveries;
	} result_t;

endpackage

// ----- rtl/core/i2c_dma_transaction_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// i2c_dma_transaction_sequencer_core: host-mode i2c transaction sequencer
// turns request, dma, interrupt and tick events into dma/bus commands and replies
// ----------------------------------------------------------------------------
// usage
//  - event channel: in_valid/in_stall carry one event per request (action plus
//    its fields); a request is taken when in_valid is high and in_stall is low
//  - result channel: out_valid/out_stall carry exactly one result per event,
//    in event order; the result is taken when out_valid is high and out_stall low
//  - config channel: cfg_valid/cfg_ready write stall_limit; cfg_ready is always
//    high, writes are meant to happen only while the block is idle
//  - pipeline: an event passes one event register and then one result register,
//    with the transaction state updated in between
//  - throughput: one event per clock if unstalled; the next-state logic is a single
//    short decode of the event against the transaction state, so nothing iterates
//  - stall: while the result register is full and stalled, the event register
//    holds its request; a new event is refused only once both are occupied
//  - reset (arst_n low): transaction idle, pending status ok, all counters zero,
//    stall_limit back to 3, both pipeline stages empty
//  - bus_error_total and stall_recoveries show the low 16 bits of counters of
//    COUNTER_WIDTH bits that saturate at their all-ones value
// ----------------------------------------------------------------------------
module i2c_dma_transaction_sequencer_core #(
	parameter int COUNTER_WIDTH = i2cseq_pkg::COUNTER_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,

	// event channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic        dma_channel,
	input  logic        irq_error,
	input  logic [5:0]  error_flags,
	input  logic        bus_owned,
	input  logic        rx_nack,
	input  logic [6:0]  device_address,
	input  logic [7:0]  write_length,
	input  logic [7:0]  read_length,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  reply_kind,
	output logic [1:0]  reply_status,
	output logic [1:0]  abort_mask,
	output logic [1:0]  queue_mask,
	output logic [1:0]  bus_start,
	output logic [6:0]  bus_address,
	output logic [7:0]  bus_length,
	output logic [1:0]  mb_irq_control,
	output logic        recover_bus,
	output logic [1:0]  warning,
	output logic [15:0] bus_error_total,
	output logic [15:0] stall_recoveries
);
	import i2cseq_pkg::*;

	// transaction states
	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_READ       = 4'd1;
	localparam logic [3:0] ST_WRITE      = 4'd2;
	localparam logic [3:0] ST_WR_WRITING = 4'd3;
	localparam logic [3:0] ST_WR_WAIT    = 4'd4;
	localparam logic [3:0] ST_WR_READING = 4'd5;
	localparam logic [3:0] ST_DONE_READ  = 4'd6;
	localparam logic [3:0] ST_DONE_WRITE = 4'd7;
	localparam logic [3:0] ST_DONE_WR    = 4'd8;

	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

	// event register
	logic        vld_s1;
	logic [2:0]  act_s1;
	logic        chan_s1;
	logic        irq_err_s1;
	logic [5:0]  eflags_s1;
	logic        mob_s1;
	logic        nack_s1;
	logic [6:0]  addr_s1;
	logic [7:0]  wlen_s1;
	logic [7:0]  rlen_s1;

	// transaction state
	logic [3:0]               state_q;
	logic [1:0]               pend_q;
	logic [6:0]               stash_addr_q;
	logic [7:0]               stash_rlen_q;
	logic [COUNTER_WIDTH-1:0] err_cnt_q;
	logic [7:0]               tick_q;
	logic [COUNTER_WIDTH-1:0] rec_cnt_q;
	logic [7:0]               stall_limit_q;

	// result register
	logic    out_vld_q;
	result_t res_q;

	// next-state and result
	logic [3:0]               state_d;
	logic [1:0]               pend_d;
	logic [6:0]               stash_addr_d;
	logic [7:0]               stash_rlen_d;
	logic [COUNTER_WIDTH-1:0] err_cnt_d;
	logic [7:0]               tick_d;
	logic [COUNTER_WIDTH-1:0] rec_cnt_d;
	result_t                  res_d;

	logic                     advance;
	logic                     do_handoff;
	logic                     in_flight;
	logic [2:0]               err_bits;
	logic [COUNTER_WIDTH:0]   err_sum;
	logic [COUNTER_WIDTH:0]   rec_sum;
	logic [7:0]               tick_inc;

	// the event stage moves on whenever the result register is free or drained
	assign advance   = !out_vld_q || !out_stall;
	assign in_stall  = vld_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_limit_q <= STALL_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			stall_limit_q <= cfg_data;
		end
	end

	// event register, an empty stage takes a request even while the output waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			act_s1     <= action;
			chan_s1    <= dma_channel;
			irq_err_s1 <= irq_error;
			eflags_s1  <= error_flags;
			mob_s1     <= bus_owned;
			nack_s1    <= rx_nack;
			addr_s1    <= device_address;
			wlen_s1    <= write_length;
			rlen_s1    <= read_length;
		end
	end

	// error flag count, each set flag is one error
	always_comb begin
		err_bits = 3'd0;
		for (int i = 0; i < 6; i++) begin
			err_bits = err_bits + {2'b00, eflags_s1[i]};
		end
	end

	assign err_sum   = {1'b0, err_cnt_q} + (COUNTER_WIDTH+1)'(err_bits);
	assign rec_sum   = {1'b0, rec_cnt_q} + (COUNTER_WIDTH+1)'(1);
	assign tick_inc  = (tick_q == TICK_MAX) ? tick_q : tick_q + 8'd1;
	assign in_flight = (state_q == ST_READ) || (state_q == ST_WRITE) ||
		(state_q == ST_WR_WRITING) || (state_q == ST_WR_WAIT) ||
		(state_q == ST_WR_READING);

	// event decode against the current transaction state
	always_comb begin
		state_d      = state_q;
		pend_d       = pend_q;
		stash_addr_d = stash_addr_q;
		stash_rlen_d = stash_rlen_q;
		err_cnt_d    = err_cnt_q;
		tick_d       = tick_q;
		rec_cnt_d    = rec_cnt_q;
		res_d        = '0;
		do_handoff   = 1'b0;

		case (act_s1)
			ACT_READ_REQ: begin
				if (state_q != ST_IDLE) begin
					res_d.reply_kind   = KIND_READ;
					res_d.reply_status = STS_OTHER_ERR;
				end else begin
					state_d           = ST_READ;
					res_d.queue_mask  = DMA_READ;
					res_d.bus_start   = BUS_READ;
					res_d.bus_address = addr_s1;
					res_d.bus_length  = rlen_s1;
				end
			end
			ACT_WRITE_REQ: begin
				if (state_q != ST_IDLE || wlen_s1 == 8'd0) begin
					res_d.reply_kind   = KIND_WRITE;
					res_d.reply_status = STS_OTHER_ERR;
				end else begin
					state_d           = ST_WRITE;
					res_d.queue_mask  = DMA_WRITE;
					res_d.bus_start   = BUS_WRITE_STOP;
					res_d.bus_address = addr_s1;
					res_d.bus_length  = wlen_s1;
				end
			end
			ACT_WR_RD_REQ: begin
				if (state_q != ST_IDLE || wlen_s1 == 8'd0 || rlen_s1 == 8'd0) begin
					res_d.reply_kind   = KIND_WR_RD;
					res_d.reply_status = STS_OTHER_ERR;
				end else begin
					// read half starts later from the stashed address and length
					state_d           = ST_WR_WRITING;
					stash_addr_d      = addr_s1;
					stash_rlen_d      = rlen_s1;
					res_d.queue_mask  = DMA_BOTH;
					res_d.bus_start   = BUS_WRITE_HOLD;
					res_d.bus_address = addr_s1;
					res_d.bus_length  = wlen_s1;
				end
			end
			ACT_DMA_DONE: begin
				if (state_q == ST_READ || state_q == ST_WR_READING) begin
					if (chan_s1 != CHAN_READ) begin
						res_d.warning = WARN_DMA;
					end else begin
						pend_d  = STS_OK;
						state_d = (state_q == ST_READ) ? ST_DONE_READ : ST_DONE_WR;
					end
				end else if (state_q == ST_WRITE || state_q == ST_WR_WRITING) begin
					if (chan_s1 != CHAN_WRITE) begin
						res_d.warning = WARN_DMA;
					end else if (state_q == ST_WRITE) begin
						pend_d  = STS_OK;
						state_d = ST_DONE_WRITE;
					end else begin
						// write half done, wait for the master-on-bus handoff
						state_d              = ST_WR_WAIT;
						res_d.mb_irq_control = MB_ENABLE;
						do_handoff           = mob_s1;
					end
				end
			end
			ACT_IRQ: begin
				if (irq_err_s1) begin
					err_cnt_d = err_sum[COUNTER_WIDTH] ? CNT_MAX : err_sum[COUNTER_WIDTH-1:0];
					case (state_q)
						ST_READ: begin
							res_d.abort_mask = DMA_READ;
							pend_d           = STS_READ_ERR;
							state_d          = ST_DONE_READ;
						end
						ST_WRITE: begin
							res_d.abort_mask = DMA_WRITE;
							pend_d           = STS_WRITE_ERR;
							state_d          = ST_DONE_WRITE;
						end
						ST_WR_WAIT, ST_WR_WRITING: begin
							if (state_q == ST_WR_WAIT) begin
								res_d.mb_irq_control = MB_DISABLE;
							end
							res_d.abort_mask = DMA_BOTH;
							pend_d           = STS_WRITE_ERR;
							state_d          = ST_DONE_WR;
						end
						ST_WR_READING: begin
							res_d.abort_mask = DMA_READ;
							pend_d           = STS_READ_ERR;
							state_d          = ST_DONE_WR;
						end
						default: begin
							res_d.warning = WARN_IRQ;
						end
					endcase
				end else if (mob_s1) begin
					if (state_q == ST_WR_WAIT) begin
						do_handoff = 1'b1;
					end else begin
						res_d.mb_irq_control = MB_DISABLE;
						res_d.warning        = WARN_IRQ;
					end
				end
			end
			ACT_DELIVER: begin
				if (state_q == ST_DONE_READ || state_q == ST_DONE_WRITE ||
						state_q == ST_DONE_WR) begin
					res_d.reply_kind   = (state_q == ST_DONE_READ)  ? KIND_READ :
						(state_q == ST_DONE_WRITE) ? KIND_WRITE : KIND_WR_RD;
					res_d.reply_status = pend_q;
					state_d            = ST_IDLE;
				end
			end
			ACT_WATCHDOG: begin
				if (!in_flight) begin
					tick_d = 8'd0;
				end else if (tick_inc >= stall_limit_q) begin
					// forced recovery, reply goes out now with other_err
					state_d = ST_IDLE;
					tick_d  = 8'd0;
					if (state_q == ST_READ) begin
						res_d.abort_mask = DMA_READ;
						res_d.reply_kind = KIND_READ;
					end else if (state_q == ST_WRITE) begin
						res_d.abort_mask = DMA_WRITE;
						res_d.reply_kind = KIND_WRITE;
					end else begin
						res_d.abort_mask = DMA_BOTH;
						res_d.reply_kind = KIND_WR_RD;
					end
					res_d.reply_status   = STS_OTHER_ERR;
					res_d.mb_irq_control = MB_DISABLE;
					res_d.recover_bus    = 1'b1;
					res_d.warning        = WARN_STALL;
					rec_cnt_d = rec_sum[COUNTER_WIDTH] ? CNT_MAX : rec_sum[COUNTER_WIDTH-1:0];
				end else begin
					tick_d = tick_inc;
				end
			end
			default: begin
				err_cnt_d = '0;
			end
		endcase

		// master-on-bus handoff in the write-then-read
		if (do_handoff) begin
			res_d.mb_irq_control = MB_DISABLE;
			if (nack_s1) begin
				res_d.abort_mask = res_d.abort_mask | DMA_READ;
				pend_d           = STS_WRITE_ERR;
				state_d          = ST_DONE_WR;
			end else begin
				state_d           = ST_WR_READING;
				res_d.bus_start   = BUS_READ;
				res_d.bus_address = stash_addr_q;
				res_d.bus_length  = stash_rlen_q;
			end
		end

		res_d.bus_error_total  = 16'(err_cnt_d);
		res_d.stall_recoveries = 16'(rec_cnt_d);
	end

	// transaction state, committed as the event moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_q       <= STS_OK;
			stash_addr_q <= '0;
			stash_rlen_q <= '0;
			err_cnt_q    <= '0;
			tick_q       <= '0;
			rec_cnt_q    <= '0;
		end else if (advance && vld_s1) begin
			state_q      <= state_d;
			pend_q       <= pend_d;
			stash_addr_q <= stash_addr_d;
			stash_rlen_q <= stash_rlen_d;
			err_cnt_q    <= err_cnt_d;
			tick_q       <= tick_d;
			rec_cnt_q    <= rec_cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			res_q <= res_d;
		end
	end

	assign out_valid        = out_vld_q;
	assign reply_kind       = res_q.reply_kind;
	assign reply_status     = res_q.reply_status;
	assign abort_mask       = res_q.abort_mask;
	assign queue_mask       = res_q.queue_mask;
	assign bus_start        = res_q.bus_start;
	assign bus_address      = res_q.bus_address;
	assign bus_length       = res_q.bus_length;
	assign mb_irq_control   = res_q.mb_irq_control;
	assign recover_bus      = res_q.recover_bus;
	assign warning          = res_q.warning;
	assign bus_error_total  = res_q.bus_error_total;
	assign stall_recoveries = res_q.stall_recoveries;

	// a status only comes with a reply
	a_status_needs_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (reply_kind != KIND_NONE || reply_status == STS_OK))
		else $error("reply status without reply kind");

	// no bus command means no address or length
	a_idle_bus_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bus_start == BUS_NONE) |-> (bus_address == 7'd0 && bus_length == 8'd0))
		else $error("bus fields set without a bus start");

	// a bus recovery is always a stall recovery with other_err and interrupt off
	a_recover_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && recover_bus) |-> (warning == WARN_STALL &&
			mb_irq_control == MB_DISABLE && reply_status == STS_OTHER_ERR))
		else $error("bus recovery with inconsistent result");

	// a new bus start only ever leaves idle or the write-then-read handoff
	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && vld_s1 && res_d.bus_start != BUS_NONE) |->
			(state_q == ST_IDLE || state_q == ST_WR_WAIT || state_q == ST_WR_WRITING))
		else $error("bus start issued mid transaction");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for the i2c dma transaction sequencer core
// drives bus, dma, interrupt and tick requests with random gaps and result
// back-pressure, predicts every result with a cycle-free model of the
// sequencer and compares each result field by field in request order
// ----------------------------------------------------------------------------
module tb;

	import i2cseq_pkg::*;

	// counters inside the block are this wide; results show the low 16 bits
	localparam int CNT_W = COUNTER_WIDTH_DEFAULT;
	// cycles allowed for outstanding results to come back before giving up
	localparam int unsigned DRAIN_LIMIT = 5000;
	// error reports printed before the rest are only counted
	localparam int unsigned REPORT_LIMIT = 10;

	// transaction phases of the predictor
	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_WRITE,
		S_WR_WRITING,
		S_WR_WAIT,
		S_WR_READING,
		S_DONE_READ,
		S_DONE_WRITE,
		S_DONE_WR
	} seq_state_t;

	// one request on the event channel
	typedef struct packed {
		logic [2:0] action;
		logic       dma_channel;
		logic       irq_error;
		logic [5:0] error_flags;
		logic       bus_owned;
		logic       rx_nack;
		logic [6:0] device_address;
		logic [7:0] write_length;
		logic [7:0] read_length;
	} bus_evt_t;

	// clock, reset and every block input start at known values
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = '0;
	logic        dma_channel = 1'b0;
	logic        irq_error = 1'b0;
	logic [5:0]  error_flags = '0;
	logic        bus_owned = 1'b0;
	logic        rx_nack = 1'b0;
	logic [6:0]  device_address = '0;
	logic [7:0]  write_length = '0;
	logic [7:0]  read_length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  reply_kind;
	logic [1:0]  reply_status;
	logic [1:0]  abort_mask;
	logic [1:0]  queue_mask;
	logic [1:0]  bus_start;
	logic [6:0]  bus_address;
	logic [7:0]  bus_length;
	logic [1:0]  mb_irq_control;
	logic        recover_bus;
	logic [1:0]  warning;
	logic [15:0] bus_error_total;
	logic [15:0] stall_recoveries;

	// predictor state, a copy of what the block should hold
	seq_state_t       seq_state = S_IDLE;
	logic [1:0]       pend_status = STS_OK;
	logic [6:0]       stash_addr = '0;
	logic [7:0]       stash_rlen = '0;
	logic [CNT_W-1:0] bus_errors = '0;
	logic [7:0]       tick_count = '0;
	logic [CNT_W-1:0] recoveries = '0;
	logic [7:0]       stall_limit_cfg = STALL_LIMIT_RESET;

	// predicted results waiting for the block, oldest first
	result_t expected_outcomes[$];

	// idle percentages of the two sides and the receiver hold-off counter
	int unsigned send_idle_pct = 6;
	int unsigned recv_idle_pct = 59;
	int unsigned hold_off_cycles = 0;
	int unsigned error_count = 0;

	i2c_dma_transaction_sequencer_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.dma_channel      (dma_channel),
		.irq_error        (irq_error),
		.error_flags      (error_flags),
		.bus_owned        (bus_owned),
		.rx_nack          (rx_nack),
		.device_address   (device_address),
		.write_length     (write_length),
		.read_length      (read_length),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.reply_kind       (reply_kind),
		.reply_status     (reply_status),
		.abort_mask       (abort_mask),
		.queue_mask       (queue_mask),
		.bus_start        (bus_start),
		.bus_address      (bus_address),
		.bus_length       (bus_length),
		.mb_irq_control   (mb_irq_control),
		.recover_bus      (recover_bus),
		.warning          (warning),
		.bus_error_total  (bus_error_total),
		.stall_recoveries (stall_recoveries)
	);

	// 4 unit period, rising edge at 2
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// counters stick at all ones
	function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt,
			input int unsigned inc);
		longint unsigned sum;
		longint unsigned top;
		top = (longint'(1) << CNT_W) - 1;
		sum = longint'(cnt) + longint'(inc);
		return (sum > top) ? top[CNT_W-1:0] : sum[CNT_W-1:0];
	endfunction

	// master-on-bus seen while the write half of a write_read has finished:
	// either the client refused the last byte or the read half is started
	function automatic void hand_off(inout result_t r, input logic nack);
		r.mb_irq_control = MB_DISABLE;
		if (nack) begin
			r.abort_mask = r.abort_mask | DMA_READ;
			pend_status = STS_WRITE_ERR;
			seq_state = S_DONE_WR;
		end else begin
			seq_state = S_WR_READING;
			r.bus_start = BUS_READ;
			r.bus_address = stash_addr;
			r.bus_length = stash_rlen;
		end
	endfunction

	// apply one request to the predictor and return the result it must cause
	function automatic result_t step_sequencer(input bus_evt_t e);
		result_t r;
		seq_state_t s;
		r = '0;
		s = seq_state;
		case (e.action)
		ACT_READ_REQ: begin
			if (s != S_IDLE) begin
				r.reply_kind = KIND_READ;
				r.reply_status = STS_OTHER_ERR;
			end else begin
				seq_state = S_READ;
				r.queue_mask = DMA_READ;
				r.bus_start = BUS_READ;
				r.bus_address = e.device_address;
				r.bus_length = e.read_length;
			end
		end
		ACT_WRITE_REQ: begin
			if (s != S_IDLE || e.write_length == 0) begin
				r.reply_kind = KIND_WRITE;
				r.reply_status = STS_OTHER_ERR;
			end else begin
				seq_state = S_WRITE;
				r.queue_mask = DMA_WRITE;
				r.bus_start = BUS_WRITE_STOP;
				r.bus_address = e.device_address;
				r.bus_length = e.write_length;
			end
		end
		ACT_WR_RD_REQ: begin
			if (s != S_IDLE || e.write_length == 0 || e.read_length == 0) begin
				r.reply_kind = KIND_WR_RD;
				r.reply_status = STS_OTHER_ERR;
			end else begin
				seq_state = S_WR_WRITING;
				stash_addr = e.device_address;
				stash_rlen = e.read_length;
				r.queue_mask = DMA_BOTH;
				r.bus_start = BUS_WRITE_HOLD;
				r.bus_address = e.device_address;
				r.bus_length = e.write_length;
			end
		end
		ACT_DMA_DONE: begin
			// completions outside a transfer in flight are dropped
			if (s == S_READ || s == S_WR_READING) begin
				if (e.dma_channel != CHAN_READ) begin
					r.warning = WARN_DMA;
				end else begin
					pend_status = STS_OK;
					seq_state = (s == S_READ) ? S_DONE_READ : S_DONE_WR;
				end
			end else if (s == S_WRITE || s == S_WR_WRITING) begin
				if (e.dma_channel != CHAN_WRITE) begin
					r.warning = WARN_DMA;
				end else if (s == S_WRITE) begin
					pend_status = STS_OK;
					seq_state = S_DONE_WRITE;
				end else begin
					seq_state = S_WR_WAIT;
					r.mb_irq_control = MB_ENABLE;
					if (e.bus_owned)
						hand_off(r, e.rx_nack);
				end
			end
		end
		ACT_IRQ: begin
			if (e.irq_error) begin
				bus_errors = sat_count(bus_errors, $countones(e.error_flags));
				case (s)
				S_READ: begin
					r.abort_mask = DMA_READ;
					pend_status = STS_READ_ERR;
					seq_state = S_DONE_READ;
				end
				S_WRITE: begin
					r.abort_mask = DMA_WRITE;
					pend_status = STS_WRITE_ERR;
					seq_state = S_DONE_WRITE;
				end
				S_WR_WAIT, S_WR_WRITING: begin
					if (s == S_WR_WAIT)
						r.mb_irq_control = MB_DISABLE;
					r.abort_mask = DMA_BOTH;
					pend_status = STS_WRITE_ERR;
					seq_state = S_DONE_WR;
				end
				S_WR_READING: begin
					r.abort_mask = DMA_READ;
					pend_status = STS_READ_ERR;
					seq_state = S_DONE_WR;
				end
				default: begin
					// counted but nothing in flight; a pending reply is kept
					r.warning = WARN_IRQ;
				end
				endcase
			end else if (e.bus_owned) begin
				if (s == S_WR_WAIT) begin
					hand_off(r, e.rx_nack);
				end else begin
					r.mb_irq_control = MB_DISABLE;
					r.warning = WARN_IRQ;
				end
			end
		end
		ACT_DELIVER: begin
			if (s == S_DONE_READ || s == S_DONE_WRITE || s == S_DONE_WR) begin
				r.reply_kind = (s == S_DONE_READ) ? KIND_READ :
					(s == S_DONE_WRITE) ? KIND_WRITE : KIND_WR_RD;
				r.reply_status = pend_status;
				seq_state = S_IDLE;
			end
		end
		ACT_WATCHDOG: begin
			if (!(s inside {S_READ, S_WRITE, S_WR_WRITING, S_WR_WAIT, S_WR_READING})) begin
				tick_count = '0;
			end else begin
				if (tick_count != TICK_MAX)
					tick_count = tick_count + 8'd1;
				if (tick_count >= stall_limit_cfg) begin
					seq_state = S_IDLE;
					tick_count = '0;
					if (s == S_READ) begin
						r.abort_mask = DMA_READ;
						r.reply_kind = KIND_READ;
					end else if (s == S_WRITE) begin
						r.abort_mask = DMA_WRITE;
						r.reply_kind = KIND_WRITE;
					end else begin
						r.abort_mask = DMA_BOTH;
						r.reply_kind = KIND_WR_RD;
					end
					r.reply_status = STS_OTHER_ERR;
					r.mb_irq_control = MB_DISABLE;
					r.recover_bus = 1'b1;
					r.warning = WARN_STALL;
					recoveries = sat_count(recoveries, 1);
				end
			end
		end
		default: begin
			bus_errors = '0;
		end
		endcase
		r.bus_error_total = bus_errors[15:0];
		r.stall_recoveries = recoveries[15:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("error at %0t: %s", $realtime, msg);
	endtask

	task automatic check_outcome(input result_t got);
		result_t want;
		string diffs;
		if (expected_outcomes.size() == 0) begin
			flag_error($sformatf("result with nothing expected: %h", got));
			return;
		end
		want = expected_outcomes.pop_front();
		diffs = "";
		if (got.reply_kind !== want.reply_kind)
			diffs = {diffs, $sformatf(" reply_kind exp %0d got %0d",
				want.reply_kind, got.reply_kind)};
		if (got.reply_status !== want.reply_status)
			diffs = {diffs, $sformatf(" reply_status exp %0d got %0d",
				want.reply_status, got.reply_status)};
		if (got.abort_mask !== want.abort_mask)
			diffs = {diffs, $sformatf(" abort_mask exp %0d got %0d",
				want.abort_mask, got.abort_mask)};
		if (got.queue_mask !== want.queue_mask)
			diffs = {diffs, $sformatf(" queue_mask exp %0d got %0d",
				want.queue_mask, got.queue_mask)};
		if (got.bus_start !== want.bus_start)
			diffs = {diffs, $sformatf(" bus_start exp %0d got %0d",
				want.bus_start, got.bus_start)};
		if (got.bus_address !== want.bus_address)
			diffs = {diffs, $sformatf(" bus_address exp %0d got %0d",
				want.bus_address, got.bus_address)};
		if (got.bus_length !== want.bus_length)
			diffs = {diffs, $sformatf(" bus_length exp %0d got %0d",
				want.bus_length, got.bus_length)};
		if (got.mb_irq_control !== want.mb_irq_control)
			diffs = {diffs, $sformatf(" mb_irq_control exp %0d got %0d",
				want.mb_irq_control, got.mb_irq_control)};
		if (got.recover_bus !== want.recover_bus)
			diffs = {diffs, $sformatf(" recover_bus exp %0d got %0d",
				want.recover_bus, got.recover_bus)};
		if (got.warning !== want.warning)
			diffs = {diffs, $sformatf(" warning exp %0d got %0d",
				want.warning, got.warning)};
		if (got.bus_error_total !== want.bus_error_total)
			diffs = {diffs, $sformatf(" bus_error_total exp %0d got %0d",
				want.bus_error_total, got.bus_error_total)};
		if (got.stall_recoveries !== want.stall_recoveries)
			diffs = {diffs, $sformatf(" stall_recoveries exp %0d got %0d",
				want.stall_recoveries, got.stall_recoveries)};
		if (diffs != "")
			flag_error({"result mismatch:", diffs});
	endtask

	// results are sampled at the rising edge, before the block updates them
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			check_outcome({reply_kind, reply_status, abort_mask, queue_mask, bus_start,
				bus_address, bus_length, mb_irq_control, recover_bus, warning,
				bus_error_total, stall_recoveries});
	end

	// receiver side: a requested hold-off wins, otherwise random stalls
	always @(negedge clk) begin
		if (hold_off_cycles != 0) begin
			hold_off_cycles = hold_off_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// a request with every field random; callers override what matters
	function automatic bus_evt_t make_evt(input logic [2:0] act);
		bus_evt_t e;
		e.action = act;
		e.dma_channel = 1'($urandom_range(1));
		e.irq_error = 1'($urandom_range(1));
		e.error_flags = 6'($urandom_range(63));
		e.bus_owned = 1'($urandom_range(1));
		e.rx_nack = 1'($urandom_range(1));
		e.device_address = 7'($urandom_range(127));
		e.write_length = 8'($urandom_range(255));
		e.read_length = 8'($urandom_range(255));
		return e;
	endfunction

	// picks a request that mostly moves the current transaction forward
	function automatic bus_evt_t pick_guided();
		bus_evt_t e;
		int unsigned roll;
		e = make_evt(ACT_CLEAR_ERR);
		roll = $urandom_range(99);
		if (roll < 12) begin
			// plain noise
			e.action = 3'($urandom_range(7));
			return e;
		end
		if (roll < 20) begin
			e.action = ACT_WATCHDOG;
			return e;
		end
		roll = $urandom_range(99);
		case (seq_state)
		S_IDLE: begin
			e.action = 3'($urandom_range(2));
			if ($urandom_range(24) == 0) begin
				// zero-length field; refused for a write or write_read that uses it, not for a read
				if ($urandom_range(1))
					e.write_length = '0;
				else
					e.read_length = '0;
			end else begin
				if (e.write_length == 0)
					e.write_length = 8'd1;
				if (e.action == ACT_WR_RD_REQ && e.read_length == 0)
					e.read_length = 8'd1;
			end
		end
		S_READ, S_WR_READING: begin
			if (roll < 75) begin
				e.action = ACT_DMA_DONE;
				e.dma_channel = ($urandom_range(19) == 0) ? CHAN_WRITE : CHAN_READ;
			end else if (roll < 88) begin
				e.action = ACT_IRQ;
				e.irq_error = 1'b1;
			end else begin
				e.action = 3'($urandom_range(2));
			end
		end
		S_WRITE, S_WR_WRITING: begin
			if (roll < 75) begin
				e.action = ACT_DMA_DONE;
				e.dma_channel = ($urandom_range(19) == 0) ? CHAN_READ : CHAN_WRITE;
				e.rx_nack = ($urandom_range(4) == 0);
			end else if (roll < 88) begin
				e.action = ACT_IRQ;
				e.irq_error = 1'b1;
			end else begin
				e.action = 3'($urandom_range(2));
			end
		end
		S_WR_WAIT: begin
			e.action = ACT_IRQ;
			if (roll < 80) begin
				e.irq_error = 1'b0;
				e.bus_owned = 1'b1;
				e.rx_nack = ($urandom_range(4) == 0);
			end else begin
				e.irq_error = 1'b1;
			end
		end
		default: begin
			// a completion is waiting for its deliver tick
			e.action = (roll < 80) ? ACT_DELIVER : 3'($urandom_range(7));
		end
		endcase
		return e;
	endfunction

	// offers one request, idling first at random; valid stays high after
	// acceptance so back-to-back requests never drop it in between
	task automatic offer_event(input bus_evt_t e);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action <= e.action;
		dma_channel <= e.dma_channel;
		irq_error <= e.irq_error;
		error_flags <= e.error_flags;
		bus_owned <= e.bus_owned;
		rx_nack <= e.rx_nack;
		device_address <= e.device_address;
		write_length <= e.write_length;
		read_length <= e.read_length;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		expected_outcomes.push_back(step_sequencer(e));
	endtask

	// stops offering and waits for every predicted result to come back
	task automatic drain_outcomes();
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_outcomes.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", expected_outcomes.size()));
			expected_outcomes.delete();
		end
	endtask

	// only written with the pipeline empty
	task automatic write_stall_limit(input logic [7:0] lim);
		drain_outcomes();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= lim;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		stall_limit_cfg = lim;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// field extremes, every action but the watchdog and the corner cases of the sequencer
	task automatic test_directed_events();
		bus_evt_t e;
		// deliver with nothing finished, plain interrupt, stray master-on-bus
		offer_event(make_evt(ACT_DELIVER));
		e = make_evt(ACT_IRQ);
		e.irq_error = 1'b0;
		e.bus_owned = 1'b0;
		offer_event(e);
		e.bus_owned = 1'b1;
		offer_event(e);
		// error interrupt while idle, all flags set
		e = make_evt(ACT_IRQ);
		e.irq_error = 1'b1;
		e.error_flags = 6'h3F;
		offer_event(e);
		offer_event(make_evt(ACT_DMA_DONE));
		offer_event(make_evt(ACT_CLEAR_ERR));
		// zero-length write is refused
		e = make_evt(ACT_WRITE_REQ);
		e.write_length = '0;
		offer_event(e);
		// read at the top address and length, then a request while busy
		e = make_evt(ACT_READ_REQ);
		e.device_address = 7'h7F;
		e.read_length = 8'hFF;
		offer_event(e);
		e = make_evt(ACT_WR_RD_REQ);
		e.write_length = 8'd9;
		e.read_length = 8'd9;
		offer_event(e);
		// wrong channel, right channel, stray completion, delivery
		e = make_evt(ACT_DMA_DONE);
		e.dma_channel = CHAN_WRITE;
		offer_event(e);
		e.dma_channel = CHAN_READ;
		offer_event(e);
		offer_event(make_evt(ACT_DMA_DONE));
		offer_event(make_evt(ACT_DELIVER));
		// write_read with zero read length is refused
		e = make_evt(ACT_WR_RD_REQ);
		e.write_length = 8'd4;
		e.read_length = '0;
		offer_event(e);
		// write_read at address zero, client refuses after the write half
		e = make_evt(ACT_WR_RD_REQ);
		e.device_address = '0;
		e.write_length = 8'hFF;
		e.read_length = 8'hFF;
		offer_event(e);
		e = make_evt(ACT_DMA_DONE);
		e.dma_channel = CHAN_WRITE;
		e.bus_owned = 1'b0;
		offer_event(e);
		e = make_evt(ACT_IRQ);
		e.irq_error = 1'b0;
		e.bus_owned = 1'b1;
		e.rx_nack = 1'b1;
		offer_event(e);
		offer_event(make_evt(ACT_DELIVER));
		// write_read with immediate handoff, then an error in the read half
		e = make_evt(ACT_WR_RD_REQ);
		e.write_length = 8'd1;
		e.read_length = 8'd1;
		offer_event(e);
		e = make_evt(ACT_DMA_DONE);
		e.dma_channel = CHAN_WRITE;
		e.bus_owned = 1'b1;
		e.rx_nack = 1'b0;
		offer_event(e);
		e = make_evt(ACT_IRQ);
		e.irq_error = 1'b1;
		offer_event(e);
		offer_event(make_evt(ACT_DELIVER));
		// single byte write killed by an error interrupt with no flags
		e = make_evt(ACT_WRITE_REQ);
		e.device_address = 7'h7F;
		e.write_length = 8'd1;
		offer_event(e);
		e = make_evt(ACT_IRQ);
		e.irq_error = 1'b1;
		e.error_flags = '0;
		offer_event(e);
		offer_event(make_evt(ACT_DELIVER));
		// zero-length read is legal
		e = make_evt(ACT_READ_REQ);
		e.read_length = '0;
		offer_event(e);
		drain_outcomes();
	endtask

	// watchdog recovery at the smallest and largest stall limits
	task automatic test_stall_limits();
		bus_evt_t e;
		// the read left over from the directed part recovers on the first tick
		write_stall_limit(8'd0);
		offer_event(make_evt(ACT_WATCHDOG));
		offer_event(make_evt(ACT_WATCHDOG));
		write_stall_limit(8'd1);
		e = make_evt(ACT_WR_RD_REQ);
		e.write_length = 8'd3;
		e.read_length = 8'd3;
		offer_event(e);
		e = make_evt(ACT_DMA_DONE);
		e.dma_channel = CHAN_WRITE;
		e.bus_owned = 1'b0;
		offer_event(e);
		offer_event(make_evt(ACT_WATCHDOG));
		offer_event(make_evt(ACT_DELIVER));
		// at the top limit the write survives 254 ticks and falls on the next
		write_stall_limit(8'hFF);
		e = make_evt(ACT_WRITE_REQ);
		e.write_length = 8'd2;
		offer_event(e);
		repeat (255)
			offer_event(make_evt(ACT_WATCHDOG));
		offer_event(make_evt(ACT_DELIVER));
		drain_outcomes();
	endtask

	// receiver holds off long enough that the block stalls its input
	task automatic test_back_pressure();
		int unsigned saved_pct;
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		hold_off_cycles = 150;
		repeat (40)
			offer_event(pick_guided());
		send_idle_pct = saved_pct;
		drain_outcomes();
	endtask

	// random traffic under one idle setting and a random stall limit
	task automatic test_random_traffic(input int unsigned send_pct,
			input int unsigned recv_pct, input int unsigned lim_lo,
			input int unsigned lim_hi, input int unsigned count);
		write_stall_limit(8'($urandom_range(lim_hi, lim_lo)));
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) begin
			offer_event(pick_guided());
			// now and then the sender waits for everything to come back
			if ($urandom_range(99) == 0)
				drain_outcomes();
		end
		drain_outcomes();
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------

	initial begin
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_events();
		test_stall_limits();
		test_back_pressure();
		test_random_traffic(6, 59, 1, 3, 270);
		test_random_traffic(59, 6, 2, 8, 270);
		test_random_traffic(0, 0, 1, 5, 270);

		// anything still arriving now is a stray result
		repeat (8)
			@(posedge clk);
		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// hard stop far beyond the slowest correct run
	initial begin
		#800000;
		$display("tb failed");
		$finish;
	end

endmodule
